@@ design/signed_vector_sum_preserving_round_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sum-preserving rounding unit
// Shared property forms, clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef SIGNED_VECTOR_SUM_PRESERVING_ROUND_UNIT_ASSERT_SVH
`define SIGNED_VECTOR_SUM_PRESERVING_ROUND_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SVSPR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("svspr assertion failed");

// Next-cycle implication.
`define SVSPR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("svspr assertion failed");

`endif

@@ design/svspr_pkg.sv @@
// ----------------------------------------------------------------------------
// svspr_pkg
// Sequencer state types shared by the rounding unit and its arithmetic unit.
// ----------------------------------------------------------------------------
package svspr_pkg;

  // Top-level sequencer phases.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PREP,
    ST_ALIGN,
    ST_SCALE,
    ST_DECIDE,
    ST_CORR,
    ST_OUT
  } state_t;

  // Multiply-divide unit phases.
  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV,
    MD_DONE
  } md_state_t;

endpackage

@@ design/svspr_cell.sv @@
// ----------------------------------------------------------------------------
// svspr_cell
// One element slot of the rotating chain: raw sample, integer part, fraction.
// ----------------------------------------------------------------------------
module svspr_cell #(
  parameter int XW = 48,
  parameter int IW = 40,
  parameter int FW = 18
) (
  input  logic                 clk,
  input  logic                 shift,
  input  logic        [XW-1:0] raw_in,
  input  logic signed [IW-1:0] ival_in,
  input  logic signed [FW-1:0] frac_in,
  output logic        [XW-1:0] raw,
  output logic signed [IW-1:0] ival,
  output logic signed [FW-1:0] frac
);

  // Take the neighbor's element whenever the chain advances.
  always_ff @(posedge clk) begin
    if (shift) begin
      raw  <= raw_in;
      ival <= ival_in;
      frac <= frac_in;
    end
  end

endmodule

@@ design/svspr_muldiv.sv @@
// ----------------------------------------------------------------------------
// svspr_muldiv
// Computes floor(a * b / d) with a shift-add multiply followed by a
// restoring divide, one bit per cycle.
// ----------------------------------------------------------------------------
`include "signed_vector_sum_preserving_round_unit_assert.svh"

module svspr_muldiv #(
  parameter int XW   = 48,
  parameter int SUMW = 56,
  parameter int MW   = 58
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [XW-1:0]   a,
  input  logic [MW-1:0]   b,
  input  logic [SUMW-1:0] d,
  output logic            done,
  output logic [MW-1:0]   q
);

  localparam int PW = XW + MW;
  localparam int NW = $clog2(PW + 1);

  svspr_pkg::md_state_t state, state_next;

  logic [XW-1:0]   a_sh;
  logic [MW-1:0]   b_r;
  logic [SUMW-1:0] d_r;
  logic [PW-1:0]   acc;
  logic [SUMW-1:0] rem;
  logic [NW-1:0]   cnt;
  logic [SUMW:0]   rem2;
  logic            ge;

  // One restoring step: bring in the next product bit and try the subtract.
  assign rem2 = {rem, acc[PW-1]};
  assign ge   = rem2 >= {1'b0, d_r};
  assign done = state == svspr_pkg::MD_DONE;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= svspr_pkg::MD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      svspr_pkg::MD_IDLE: begin
        if (start) state_next = svspr_pkg::MD_MUL;
      end
      svspr_pkg::MD_MUL: begin
        if (cnt == NW'(1)) state_next = svspr_pkg::MD_DIV;
      end
      svspr_pkg::MD_DIV: begin
        if (cnt == NW'(1)) state_next = svspr_pkg::MD_DONE;
      end
      svspr_pkg::MD_DONE: begin
        state_next = svspr_pkg::MD_IDLE;
      end
      default: begin
        state_next = svspr_pkg::MD_IDLE;
      end
    endcase
  end

  // Datapath: multiplier bits MSB first, then quotient bits MSB first.
  always_ff @(posedge clk) begin
    case (state)
      svspr_pkg::MD_IDLE: begin
        if (start) begin
          a_sh <= a;
          b_r  <= b;
          d_r  <= d;
          acc  <= '0;
          cnt  <= NW'(XW);
        end
      end
      svspr_pkg::MD_MUL: begin
        acc  <= (acc << 1) + (a_sh[XW-1] ? PW'(b_r) : PW'(0));
        a_sh <= a_sh << 1;
        cnt  <= cnt - NW'(1);
        if (cnt == NW'(1)) begin
          cnt <= NW'(PW);
          rem <= '0;
          q   <= '0;
        end
      end
      svspr_pkg::MD_DIV: begin
        rem <= ge ? SUMW'(rem2 - {1'b0, d_r}) : SUMW'(rem2);
        q   <= {q[MW-2:0], ge};
        acc <= acc << 1;
        cnt <= cnt - NW'(1);
      end
      default: begin
      end
    endcase
  end

  `SVSPR_ASSERT_NOW(a_start_idle, start, state == svspr_pkg::MD_IDLE)
  `SVSPR_ASSERT_NEXT(a_done_ret, done, state == svspr_pkg::MD_IDLE)
  `SVSPR_ASSERT_NOW(a_rem_bound, state == svspr_pkg::MD_DIV, rem < d_r)

endmodule

@@ design/signed_vector_sum_preserving_round_unit.sv @@
// ----------------------------------------------------------------------------
// signed_vector_sum_preserving_round_unit
// Rounds a signed Q.F vector to integers whose sum follows a target, with
// largest-remainder correction, over a rotating chain of element cells.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload (low bit up)                      Transfer when
//  s_*      in   tdata: sample[47:0], target_sum[95:48];   s_tvalid & s_tready
//                tlast: last_in
//  m_*      out  tdata: rounded[31:0]; tlast: last_out     m_tvalid & m_tready
//
//  Loading accepts one element per cycle. After the last element a setup state
//  runs, then the chain is aligned, then scaled element by element in the shared
//  multiply-divide unit (a shift-add multiply and a restoring divide; the
//  divide grows with MAX_ELEMENTS). Unused slots pass without the unit.
//  Each correction costs a decide state and one full rotation of the chain,
//  and the output rotation can be held by sink stalls.
//  s_tready is high only while loading; rst is synchronous, active high.
// ----------------------------------------------------------------------------
`include "signed_vector_sum_preserving_round_unit_assert.svh"

module signed_vector_sum_preserving_round_unit #(
  parameter int MAX_ELEMENTS = 64,
  parameter int FRAC_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // sample[47:0], target_sum[95:48]
  input  logic        s_tlast,   // last_in
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // rounded[31:0]
  output logic        m_tlast    // last_out
);

  localparam int XW   = 48;
  localparam int CW   = $clog2(MAX_ELEMENTS + 1);
  localparam int SUMW = XW + CW + 1;
  localparam int KW   = SUMW + 1;
  localparam int MW   = SUMW + 2;
  localparam int IW   = MW - FRAC_BITS + 2;
  localparam int FW   = FRAC_BITS + 2;
  localparam int FSW  = FRAC_BITS + CW + 2;

  localparam logic [CW-1:0]         MAXC   = CW'(MAX_ELEMENTS);
  localparam logic [CW-1:0]         LASTP  = CW'(MAX_ELEMENTS - 1);
  localparam logic signed [FW-1:0]  HALF_Q = FW'(2 ** (FRAC_BITS - 1));
  localparam logic signed [FSW-1:0] ONE_Q  = FSW'(2 ** FRAC_BITS);
  localparam logic signed [FSW-1:0] NT_Q   = FSW'((9 * (2 ** FRAC_BITS)) / 10);

  svspr_pkg::state_t state, state_next;

  // Per-vector registers.
  logic        [SUMW-1:0] pos_total, neg_total, dsum;
  logic signed [KW-1:0]   scale_k;
  logic        [XW-1:0]   target;
  logic                   dzero;
  logic        [CW-1:0]   cnt, acnt, p;
  logic signed [FSW-1:0]  frac_sum;
  logic        [CW-1:0]   up_pending, down_pending;
  logic signed [FW-1:0]   bestp, bestn;
  logic        [CW-1:0]   bpi, bni, up_idx, dn_idx;
  logic                   up_flag, dn_flag, md_active;

  // Chain wiring.
  logic        [XW-1:0] c_raw  [MAX_ELEMENTS];
  logic signed [IW-1:0] c_ival [MAX_ELEMENTS];
  logic signed [FW-1:0] c_frac [MAX_ELEMENTS];
  logic        [XW-1:0] head_raw;
  logic signed [IW-1:0] head_ival;
  logic signed [FW-1:0] head_frac;
  logic                 shift, step, load_shift, load_out, in_xfer;

  logic        [XW-1:0] sample, t_raw, xmag;
  logic signed [IW-1:0] t_ival;
  logic signed [FW-1:0] t_frac;
  logic                 pvalid;

  // Scaling datapath.
  logic signed [MW-1:0] mval;
  logic        [MW-1:0] mmag, q;
  logic                 neg, md_start, md_done;
  logic signed [IW-1:0] sc_ival;
  logic signed [FW-1:0] sc_frac;
  logic                 hit_up, hit_dn;

  // Magnitude of an incoming negative sample.
  function automatic logic [XW-1:0] xmag_in(input logic [XW-1:0] v);
    xmag_in = XW'(~v + XW'(1));
  endfunction

  assign sample  = s_tdata[47:0];
  assign in_xfer = s_tvalid && s_tready;
  assign s_tready = state == svspr_pkg::ST_LOAD;

  assign t_raw  = c_raw[MAX_ELEMENTS-1];
  assign t_ival = c_ival[MAX_ELEMENTS-1];
  assign t_frac = c_frac[MAX_ELEMENTS-1];
  assign pvalid = p < cnt;

  // Element chain: the head takes a new sample or the reworked tail element.
  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    if (i == 0) begin : g_head
      svspr_cell #(.XW(XW), .IW(IW), .FW(FW)) u_cell (
        .clk     (clk),
        .shift   (shift),
        .raw_in  (head_raw),
        .ival_in (head_ival),
        .frac_in (head_frac),
        .raw     (c_raw[i]),
        .ival    (c_ival[i]),
        .frac    (c_frac[i])
      );
    end else begin : g_body
      svspr_cell #(.XW(XW), .IW(IW), .FW(FW)) u_cell (
        .clk     (clk),
        .shift   (shift),
        .raw_in  (c_raw[i-1]),
        .ival_in (c_ival[i-1]),
        .frac_in (c_frac[i-1]),
        .raw     (c_raw[i]),
        .ival    (c_ival[i]),
        .frac    (c_frac[i])
      );
    end
  end

  // Scale factor for the tail element: D + k for x >= 0, D - k otherwise.
  assign xmag = t_raw[XW-1] ? XW'(~t_raw + XW'(1)) : t_raw;
  assign mval = t_raw[XW-1] ? ({2'b00, dsum} - {scale_k[KW-1], scale_k})
                            : ({2'b00, dsum} + {scale_k[KW-1], scale_k});
  assign mmag = mval[MW-1] ? MW'(-mval) : MW'(mval);
  assign neg  = t_raw[XW-1] ^ mval[MW-1];

  assign md_start = (state == svspr_pkg::ST_SCALE) && pvalid && !dzero && !md_active;

  svspr_muldiv #(.XW(XW), .SUMW(SUMW), .MW(MW)) u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (md_start),
    .a     (xmag),
    .b     (mmag),
    .d     (dsum),
    .done  (md_done),
    .q     (q)
  );

  // Split the quotient into a truncated integer and a signed fraction.
  always_comb begin
    sc_ival = neg ? -$signed({2'b00, q[MW-1:FRAC_BITS]}) : $signed({2'b00, q[MW-1:FRAC_BITS]});
    sc_frac = neg ? -$signed({2'b00, q[FRAC_BITS-1:0]}) : $signed({2'b00, q[FRAC_BITS-1:0]});
    if (dzero) begin
      sc_ival = '0;
      sc_frac = '0;
    end
  end

  assign hit_up = up_flag && (p == up_idx);
  assign hit_dn = dn_flag && (p == dn_idx);

  // Chain advance and the value re-entering at the head.
  always_comb begin
    load_shift = 1'b0;
    load_out   = 1'b0;
    step       = 1'b0;
    head_raw   = t_raw;
    head_ival  = t_ival;
    head_frac  = t_frac;
    case (state)
      svspr_pkg::ST_LOAD: begin
        load_shift = in_xfer && (cnt < MAXC);
        head_raw   = sample;
        head_ival  = '0;
        head_frac  = '0;
      end
      svspr_pkg::ST_ALIGN: begin
        step = acnt != '0;
      end
      svspr_pkg::ST_SCALE: begin
        step = !pvalid || dzero || md_done;
        if (pvalid) begin
          head_ival = sc_ival;
          head_frac = sc_frac;
        end
      end
      svspr_pkg::ST_CORR: begin
        step = 1'b1;
        if (pvalid) begin
          head_ival = t_ival + (hit_up ? IW'(1) : IW'(0)) - (hit_dn ? IW'(1) : IW'(0));
          if (hit_up || hit_dn) head_frac = '0;
        end
      end
      svspr_pkg::ST_OUT: begin
        load_out = pvalid && (!m_tvalid || m_tready);
        step     = !pvalid || load_out;
      end
      default: begin
      end
    endcase
  end

  assign shift = load_shift || step;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= svspr_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      svspr_pkg::ST_LOAD: begin
        if (in_xfer && s_tlast) state_next = svspr_pkg::ST_PREP;
      end
      svspr_pkg::ST_PREP: begin
        state_next = svspr_pkg::ST_ALIGN;
      end
      svspr_pkg::ST_ALIGN: begin
        if (acnt == '0) state_next = svspr_pkg::ST_SCALE;
      end
      svspr_pkg::ST_SCALE, svspr_pkg::ST_CORR: begin
        if (step && p == LASTP) state_next = svspr_pkg::ST_DECIDE;
      end
      svspr_pkg::ST_DECIDE: begin
        if (frac_sum > NT_Q || frac_sum < -NT_Q ||
            (up_pending != '0 && down_pending != '0)) begin
          state_next = svspr_pkg::ST_CORR;
        end else begin
          state_next = svspr_pkg::ST_OUT;
        end
      end
      svspr_pkg::ST_OUT: begin
        if (step && p == LASTP) state_next = svspr_pkg::ST_LOAD;
      end
      default: begin
        state_next = svspr_pkg::ST_LOAD;
      end
    endcase
  end

  // Control counters, totals and the correction bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_total    <= '0;
      neg_total    <= '0;
      cnt          <= '0;
      acnt         <= '0;
      p            <= '0;
      frac_sum     <= '0;
      up_pending   <= '0;
      down_pending <= '0;
      up_flag      <= 1'b0;
      dn_flag      <= 1'b0;
      md_active    <= 1'b0;
      bestp        <= '0;
      bestn        <= '0;
      bpi          <= '0;
      bni          <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (m_tready && !load_out) m_tvalid <= 1'b0;
      if (md_start) md_active <= 1'b1;
      if (md_done) md_active <= 1'b0;

      // Position of the tail element within the pass.
      if (step && state != svspr_pkg::ST_ALIGN) begin
        p <= (p == LASTP) ? '0 : p + CW'(1);
      end

      // Track the largest positive and most negative fraction entering the head.
      if (step && pvalid &&
          (state == svspr_pkg::ST_SCALE || state == svspr_pkg::ST_CORR)) begin
        if (head_frac > bestp) begin
          bestp <= head_frac;
          bpi   <= p;
        end
        if (head_frac < bestn) begin
          bestn <= head_frac;
          bni   <= p;
        end
      end

      case (state)
        svspr_pkg::ST_LOAD: begin
          if (load_shift) begin
            cnt <= cnt + CW'(1);
            if (sample[XW-1]) neg_total <= neg_total + SUMW'(xmag_in(sample));
            else              pos_total <= pos_total + SUMW'(sample);
          end
          if (in_xfer && s_tlast) target <= s_tdata[95:48];
        end
        svspr_pkg::ST_PREP: begin
          acnt         <= MAXC - cnt;
          frac_sum     <= '0;
          up_pending   <= '0;
          down_pending <= '0;
          up_flag      <= 1'b0;
          dn_flag      <= 1'b0;
          bestp        <= '0;
          bestn        <= '0;
          bpi          <= '0;
          bni          <= '0;
          p            <= '0;
        end
        svspr_pkg::ST_ALIGN: begin
          if (acnt != '0) acnt <= acnt - CW'(1);
        end
        svspr_pkg::ST_SCALE: begin
          if (step && pvalid) begin
            frac_sum <= frac_sum + FSW'(head_frac);
            if (!t_raw[XW-1] && head_frac > HALF_Q) up_pending <= up_pending + CW'(1);
            if (t_raw[XW-1] && head_frac < -HALF_Q) down_pending <= down_pending + CW'(1);
          end
        end
        svspr_pkg::ST_DECIDE: begin
          bestp   <= '0;
          bestn   <= '0;
          bpi     <= '0;
          bni     <= '0;
          up_idx  <= bpi;
          dn_idx  <= bni;
          if (frac_sum > NT_Q) begin
            up_flag  <= 1'b1;
            dn_flag  <= 1'b0;
            frac_sum <= frac_sum - ONE_Q;
            if (up_pending != '0) up_pending <= up_pending - CW'(1);
          end else if (frac_sum < -NT_Q) begin
            up_flag  <= 1'b0;
            dn_flag  <= 1'b1;
            frac_sum <= frac_sum + ONE_Q;
            if (down_pending != '0) down_pending <= down_pending - CW'(1);
          end else if (up_pending != '0 && down_pending != '0) begin
            up_flag      <= 1'b1;
            dn_flag      <= 1'b1;
            up_pending   <= up_pending - CW'(1);
            down_pending <= down_pending - CW'(1);
          end else begin
            up_flag <= 1'b0;
            dn_flag <= 1'b0;
          end
        end
        svspr_pkg::ST_OUT: begin
          if (load_out) m_tvalid <= 1'b1;
          if (step && p == LASTP) begin
            pos_total <= '0;
            neg_total <= '0;
            cnt       <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Divisor and scale numerator, formed once per vector.
  always_ff @(posedge clk) begin
    if (state == svspr_pkg::ST_PREP) begin
      dsum    <= pos_total + neg_total;
      dzero   <= (pos_total + neg_total) == '0;
      scale_k <= {{(KW - XW){target[XW-1]}}, target} - {1'b0, pos_total}
                 + {1'b0, neg_total};
    end
  end

  // Output register, saturated to 32 bits.
  always_ff @(posedge clk) begin
    if (load_out) begin
      if (t_ival[IW-1:31] == {(IW - 31){t_ival[IW-1]}}) m_tdata <= t_ival[31:0];
      else m_tdata <= t_ival[IW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
      m_tlast <= p == cnt - CW'(1);
    end
  end

  `SVSPR_ASSERT_NOW(a_done_scale, md_done, state == svspr_pkg::ST_SCALE && md_active && pvalid)
  `SVSPR_ASSERT_NOW(a_cnt_cap, 1'b1, cnt <= MAXC)
  `SVSPR_ASSERT_NOW(a_cnt_busy, state != svspr_pkg::ST_LOAD, cnt != '0)

endmodule
